// ===== rtl/core/rsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Rolling standard deviation package
// Widths, sequencer states and unit status shared by the core's modules.
// ----------------------------------------------------------------------------
package rsd_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int RING_AW     = $clog2(MAX_WINDOW);

    localparam int WL_W        = 7;
    localparam int SAMPLE_W    = 24;
    localparam int SUM_W       = 31;
    localparam int SQSUM_W     = 54;
    localparam int MAG_W       = 30;
    localparam int PROD_W      = 2 * MAG_W;
    localparam int NUM_W       = SQSUM_W + WL_W;

    // The variance is below 2**47, so 48 quotient bits, two per step.
    localparam int DIV_W       = 13;
    localparam int QUO_W       = 48;
    localparam int DIV_STEPS   = QUO_W / 2;
    localparam int DIV_T_W     = DIV_W + 2;

    localparam int ROOT_W      = 24;
    localparam int SQRT_STEPS  = QUO_W / 2;
    localparam int SQRT_REM_W  = ROOT_W + 2;
    localparam int SQRT_T_W    = ROOT_W + 4;

    localparam int STEP_CNT_W  = $clog2(DIV_STEPS > SQRT_STEPS ? DIV_STEPS : SQRT_STEPS);

    localparam logic [WL_W-1:0] WL_RESET = 7'd20;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_NEW,
        ST_SQ_OLD,
        ST_SQ_DONE,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } rsd_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rsd_unit_status_t;

endpackage

// ===== rtl/core/rsd_ring.sv =====
// ----------------------------------------------------------------------------
// Sample ring
// One write port and one registered read port; a read and a write to the
// same slot in one cycle return the old contents.
// ----------------------------------------------------------------------------
module rsd_ring (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [rsd_pkg::RING_AW-1:0]      wr_addr,
    input  logic [rsd_pkg::SAMPLE_W-1:0]     wr_data,
    input  logic                             rd_en,
    input  logic [rsd_pkg::RING_AW-1:0]      rd_addr,
    output logic [rsd_pkg::SAMPLE_W-1:0]     rd_data_reg
);

    logic [rsd_pkg::SAMPLE_W-1:0] mem [rsd_pkg::MAX_WINDOW];

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/rsd_divider.sv =====
// ----------------------------------------------------------------------------
// Radix-4 serial divider
// Divides the variance numerator by the squared window length, two quotient
// bits per cycle shifted into the dividend register.
// ----------------------------------------------------------------------------
module rsd_divider (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,
    input  logic [rsd_pkg::NUM_W-1:0]       dividend,
    input  logic [rsd_pkg::DIV_W-1:0]       divisor,
    output rsd_pkg::rsd_unit_status_t       status,
    output logic [rsd_pkg::QUO_W-1:0]       quotient
);

    logic [rsd_pkg::DIV_W-1:0]      rem_reg, rem_next;
    logic [rsd_pkg::QUO_W-1:0]      dvd_reg, dvd_next;
    logic [rsd_pkg::DIV_W-1:0]      d_reg, d_next;
    logic [rsd_pkg::DIV_T_W-1:0]    d3_reg, d3_next;
    logic [rsd_pkg::STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;

    logic [rsd_pkg::DIV_T_W-1:0]    t;
    logic [rsd_pkg::DIV_T_W-1:0]    d1;
    logic [rsd_pkg::DIV_T_W-1:0]    d2;
    logic [rsd_pkg::DIV_T_W-1:0]    t_sub;
    logic [1:0]                     digit;

    assign d1 = rsd_pkg::DIV_T_W'(d_reg);
    assign d2 = rsd_pkg::DIV_T_W'({d_reg, 1'b0});
    assign t  = {rem_reg, dvd_reg[rsd_pkg::QUO_W-1 -: 2]};

    always_comb begin
        priority if (t >= d3_reg) begin
            digit = 2'd3;
            t_sub = t - d3_reg;
        end else if (t >= d2) begin
            digit = 2'd2;
            t_sub = t - d2;
        end else if (t >= d1) begin
            digit = 2'd1;
            t_sub = t - d1;
        end else begin
            digit = 2'd0;
            t_sub = t;
        end
    end

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        d_next    = d_reg;
        d3_next   = d3_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (load) begin
            // The top bits of the numerator are already below the divisor.
            rem_next  = dividend[rsd_pkg::NUM_W-1:rsd_pkg::QUO_W];
            dvd_next  = dividend[rsd_pkg::QUO_W-1:0];
            d_next    = divisor;
            d3_next   = rsd_pkg::DIV_T_W'(divisor) + rsd_pkg::DIV_T_W'({divisor, 1'b0});
            cnt_next  = rsd_pkg::STEP_CNT_W'(rsd_pkg::DIV_STEPS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = t_sub[rsd_pkg::DIV_W-1:0];
            dvd_next = {dvd_reg[rsd_pkg::QUO_W-3:0], digit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        d_reg   <= d_next;
        d3_reg  <= d3_next;
        cnt_reg <= cnt_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = dvd_reg;

endmodule

// ===== rtl/core/rsd_sqrt.sv =====
// ----------------------------------------------------------------------------
// Serial integer square root
// Digit-by-digit floor square root, two radicand bits and one root bit per
// cycle.
// ----------------------------------------------------------------------------
module rsd_sqrt (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,
    input  logic [rsd_pkg::QUO_W-1:0]       radicand,
    output rsd_pkg::rsd_unit_status_t       status,
    output logic [rsd_pkg::ROOT_W-1:0]      root
);

    logic [rsd_pkg::QUO_W-1:0]      x_reg, x_next;
    logic [rsd_pkg::SQRT_REM_W-1:0] rem_reg, rem_next;
    logic [rsd_pkg::ROOT_W-1:0]     root_reg, root_next;
    logic [rsd_pkg::STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;

    logic [rsd_pkg::SQRT_T_W-1:0]   t;
    logic [rsd_pkg::SQRT_T_W-1:0]   trial;
    logic [rsd_pkg::SQRT_T_W-1:0]   t_sub;

    assign t     = {rem_reg, x_reg[rsd_pkg::QUO_W-1 -: 2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign t_sub = t - trial;

    always_comb begin
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (load) begin
            x_next    = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = rsd_pkg::STEP_CNT_W'(rsd_pkg::SQRT_STEPS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            x_next = {x_reg[rsd_pkg::QUO_W-3:0], 2'b00};
            if (t >= trial) begin
                rem_next  = t_sub[rsd_pkg::SQRT_REM_W-1:0];
                root_next = {root_reg[rsd_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = t[rsd_pkg::SQRT_REM_W-1:0];
                root_next = {root_reg[rsd_pkg::ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign root        = root_reg;

endmodule

// ===== rtl/core/rolling_standard_deviation_core.sv =====
// ----------------------------------------------------------------------------
// Rolling standard deviation core
// Population standard deviation over the last window_length samples.
//   s_valid/s_ready carry one word: a signed Q12.12 sample and series_start.
//   m_valid/m_ready carry one word: std_dev (unsigned Q12.12) and window_full.
//   cfg_valid/cfg_ready write window_length while no word is being worked on;
//   every write clears the history, and a pending write holds off s_ready.
// One word is worked on at a time. With a full window a word passes through the
// squaring states and then the 24-step radix-4 divider followed by the 24-step
// square root before m_valid; before the window is full it skips the divider
// and the square root and goes straight on to the output register.
// Reset sets window_length to 20 and clears the history; the sample ring
// needs no clearing. A stalled receiver leaves the result in the output
// register; the next word is still taken, then waits in ST_DONE for space.
// ----------------------------------------------------------------------------
module rolling_standard_deviation_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [rsd_pkg::SAMPLE_W-1:0]    s_sample,
    input  logic                            s_series_start,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rsd_pkg::ROOT_W-1:0]      m_std_dev,
    output logic                            m_window_full,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rsd_pkg::WL_W-1:0]        cfg_data
);

    rsd_pkg::rsd_state_t state_reg, state_next;

    logic [rsd_pkg::WL_W-1:0]            wl_reg, wl_next;
    logic [rsd_pkg::RING_AW-1:0]         ws_reg, ws_next;
    logic [rsd_pkg::WL_W-1:0]            seen_reg, seen_next;
    logic signed [rsd_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [rsd_pkg::SQSUM_W-1:0]         sq_reg, sq_next;
    logic signed [rsd_pkg::SAMPLE_W-1:0] x_reg, x_next;
    logic                                evict_reg, evict_next;
    logic                                full_reg, full_next;
    logic [rsd_pkg::PROD_W-1:0]          prod_reg, prod_next;
    logic [rsd_pkg::NUM_W-1:0]           pnum_reg, pnum_next;
    logic [rsd_pkg::ROOT_W-1:0]          root_reg, root_next;
    logic                                m_valid_reg, m_valid_next;
    logic [rsd_pkg::ROOT_W-1:0]          m_std_reg, m_std_next;
    logic                                m_full_reg, m_full_next;

    logic [rsd_pkg::WL_W-1:0]            p_eff;
    logic [2*rsd_pkg::WL_W-1:0]          p_sq;
    logic [rsd_pkg::RING_AW-1:0]         ws_eff;
    logic [rsd_pkg::RING_AW-1:0]         ws_adv;
    logic [rsd_pkg::RING_AW:0]           old_raw;
    logic [rsd_pkg::RING_AW-1:0]         old_slot;
    logic [rsd_pkg::WL_W-1:0]            seen_eff;
    logic [rsd_pkg::WL_W-1:0]            seen_upd;
    logic                                evict;

    logic                                ring_wr;
    logic                                ring_rd;
    logic [rsd_pkg::SAMPLE_W-1:0]        ring_rd_data;
    logic signed [rsd_pkg::SAMPLE_W-1:0] old_s;
    logic signed [rsd_pkg::SUM_W-1:0]    old_term;

    logic [rsd_pkg::SAMPLE_W-1:0]        x_abs;
    logic [rsd_pkg::SAMPLE_W-1:0]        old_abs;
    logic [rsd_pkg::SUM_W-1:0]           sum_abs;
    logic [rsd_pkg::MAG_W-1:0]           mul_a;
    logic [rsd_pkg::PROD_W-1:0]          mul_sq;
    logic [rsd_pkg::NUM_W-1:0]           prod_ext;
    logic [rsd_pkg::NUM_W-1:0]           diff;

    logic                                div_load;
    rsd_pkg::rsd_unit_status_t           div_status;
    logic [rsd_pkg::QUO_W-1:0]           div_quotient;
    logic                                sqrt_load;
    rsd_pkg::rsd_unit_status_t           sqrt_status;
    logic [rsd_pkg::ROOT_W-1:0]          sqrt_root;

    // A zero window length counts as one, anything above the ring as the ring.
    always_comb begin
        priority if (wl_reg == '0) begin
            p_eff = rsd_pkg::WL_W'(1);
        end else if (wl_reg > rsd_pkg::WL_W'(rsd_pkg::MAX_WINDOW)) begin
            p_eff = rsd_pkg::WL_W'(rsd_pkg::MAX_WINDOW);
        end else begin
            p_eff = wl_reg;
        end
    end

    assign p_sq     = p_eff * p_eff;
    assign ws_eff   = s_series_start ? '0 : ws_reg;
    assign ws_adv   = (ws_eff == rsd_pkg::RING_AW'(rsd_pkg::MAX_WINDOW - 1)) ?
                      '0 : ws_eff + 1'b1;
    assign old_raw  = {1'b0, ws_eff} + (rsd_pkg::RING_AW+1)'(rsd_pkg::MAX_WINDOW)
                      - (rsd_pkg::RING_AW+1)'(p_eff);
    assign old_slot = (old_raw >= (rsd_pkg::RING_AW+1)'(rsd_pkg::MAX_WINDOW)) ?
                      rsd_pkg::RING_AW'(old_raw - (rsd_pkg::RING_AW+1)'(rsd_pkg::MAX_WINDOW)) :
                      old_raw[rsd_pkg::RING_AW-1:0];
    assign seen_eff = s_series_start ? '0 : seen_reg;
    assign evict    = (seen_eff >= p_eff);
    assign seen_upd = evict ? seen_eff : seen_eff + 1'b1;

    assign old_s    = $signed(ring_rd_data);
    assign old_term = evict_reg ? rsd_pkg::SUM_W'(old_s) : '0;
    assign x_abs    = x_reg[rsd_pkg::SAMPLE_W-1] ? -x_reg : x_reg;
    assign old_abs  = old_s[rsd_pkg::SAMPLE_W-1] ? -old_s : old_s;
    assign sum_abs  = sum_reg[rsd_pkg::SUM_W-1] ? -sum_reg : sum_reg;
    assign mul_sq   = mul_a * mul_a;
    assign prod_ext = rsd_pkg::NUM_W'(prod_reg);
    assign diff     = (pnum_reg > prod_ext) ? pnum_reg - prod_ext : '0;

    rsd_ring u_ring (
        .aclk        (aclk),
        .wr_en       (ring_wr),
        .wr_addr     (ws_eff),
        .wr_data     (s_sample),
        .rd_en       (ring_rd),
        .rd_addr     (old_slot),
        .rd_data_reg (ring_rd_data)
    );

    rsd_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (div_load),
        .dividend (diff),
        .divisor  (p_sq[rsd_pkg::DIV_W-1:0]),
        .status   (div_status),
        .quotient (div_quotient)
    );

    rsd_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (sqrt_load),
        .radicand (div_quotient),
        .status   (sqrt_status),
        .root     (sqrt_root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rsd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        wl_next      = wl_reg;
        ws_next      = ws_reg;
        seen_next    = seen_reg;
        sum_next     = sum_reg;
        sq_next      = sq_reg;
        x_next       = x_reg;
        evict_next   = evict_reg;
        full_next    = full_reg;
        prod_next    = prod_reg;
        pnum_next    = pnum_reg;
        root_next    = root_reg;
        m_valid_next = m_valid_reg;
        m_std_next   = m_std_reg;
        m_full_next  = m_full_reg;
        mul_a        = '0;
        ring_wr      = 1'b0;
        ring_rd      = 1'b0;
        div_load     = 1'b0;
        sqrt_load    = 1'b0;

        if (cfg_valid && cfg_ready) begin
            wl_next   = cfg_data;
            ws_next   = '0;
            seen_next = '0;
            sum_next  = '0;
            sq_next   = '0;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            rsd_pkg::ST_IDLE: begin
                if (s_valid && !cfg_valid) begin
                    x_next     = s_sample;
                    ring_wr    = 1'b1;
                    ring_rd    = 1'b1;
                    ws_next    = ws_adv;
                    seen_next  = seen_upd;
                    evict_next = evict;
                    full_next  = (seen_upd >= p_eff);
                    if (s_series_start) begin
                        sum_next = '0;
                        sq_next  = '0;
                    end
                    state_next = rsd_pkg::ST_SQ_NEW;
                end
            end
            rsd_pkg::ST_SQ_NEW: begin
                mul_a      = rsd_pkg::MAG_W'(x_abs);
                prod_next  = mul_sq;
                sum_next   = sum_reg + rsd_pkg::SUM_W'(x_reg) - old_term;
                state_next = rsd_pkg::ST_SQ_OLD;
            end
            rsd_pkg::ST_SQ_OLD: begin
                mul_a      = rsd_pkg::MAG_W'(old_abs);
                prod_next  = mul_sq;
                sq_next    = sq_reg + rsd_pkg::SQSUM_W'(prod_reg);
                state_next = rsd_pkg::ST_SQ_DONE;
            end
            rsd_pkg::ST_SQ_DONE: begin
                if (evict_reg) begin
                    sq_next = sq_reg - rsd_pkg::SQSUM_W'(prod_reg);
                end
                if (full_reg) begin
                    state_next = rsd_pkg::ST_MUL;
                end else begin
                    root_next  = '0;
                    state_next = rsd_pkg::ST_DONE;
                end
            end
            rsd_pkg::ST_MUL: begin
                mul_a      = sum_abs[rsd_pkg::MAG_W-1:0];
                prod_next  = mul_sq;
                pnum_next  = rsd_pkg::NUM_W'(p_eff) * rsd_pkg::NUM_W'(sq_reg);
                state_next = rsd_pkg::ST_LOAD;
            end
            rsd_pkg::ST_LOAD: begin
                div_load   = 1'b1;
                state_next = rsd_pkg::ST_DIV;
            end
            rsd_pkg::ST_DIV: begin
                if (div_status.done) begin
                    sqrt_load  = 1'b1;
                    state_next = rsd_pkg::ST_SQRT;
                end
            end
            rsd_pkg::ST_SQRT: begin
                if (sqrt_status.done) begin
                    root_next  = sqrt_root;
                    state_next = rsd_pkg::ST_DONE;
                end
            end
            rsd_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_std_next   = root_reg;
                    m_full_next  = full_reg;
                    state_next   = rsd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rsd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg      <= rsd_pkg::WL_RESET;
            ws_reg      <= '0;
            seen_reg    <= '0;
            sum_reg     <= '0;
            sq_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            wl_reg      <= wl_next;
            ws_reg      <= ws_next;
            seen_reg    <= seen_next;
            sum_reg     <= sum_next;
            sq_reg      <= sq_next;
            m_valid_reg <= m_valid_next;
        end
        x_reg      <= x_next;
        evict_reg  <= evict_next;
        full_reg   <= full_next;
        prod_reg   <= prod_next;
        pnum_reg   <= pnum_next;
        root_reg   <= root_next;
        m_std_reg  <= m_std_next;
        m_full_reg <= m_full_next;
    end

    // A configuration write takes the idle slot ahead of a sample word.
    assign s_ready       = (state_reg == rsd_pkg::ST_IDLE) && !cfg_valid;
    assign cfg_ready     = (state_reg == rsd_pkg::ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_std_dev     = m_std_reg;
    assign m_window_full = m_full_reg;

`ifndef ASSERT_OFF
    a_ready_units_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_status.busy && !sqrt_status.busy)
        else $error("input ready while a serial unit is busy");

    a_not_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_window_full |-> m_std_dev == '0)
        else $error("nonzero result before the window is full");

    a_div_running: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rsd_pkg::ST_DIV |-> div_status.busy || div_status.done)
        else $error("waiting on a divider that is not running");

    a_sqrt_running: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rsd_pkg::ST_SQRT |-> sqrt_status.busy || sqrt_status.done)
        else $error("waiting on a square root unit that is not running");

    a_seen_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg <= p_eff)
        else $error("sample count exceeds the window length");
`endif

endmodule

// ===== bench/tb_rolling_standard_deviation_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rolling standard deviation core testbench
// Sends signed Q12.12 sample words through the valid/ready input and predicts
// each std_dev and window_full word with a scoreboard model that tracks the
// window ring, its running sum and its sum of squares. Directed sequences come
// first: the reset window, extreme samples, degenerate and rewritten window
// lengths and series restarts. Random series follow over many window lengths
// with idle and stall phases on both channels.
// ----------------------------------------------------------------------------
module tb_rolling_standard_deviation_core;

    localparam logic [rsd_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 24'h7FFFFF;
    localparam logic [rsd_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 24'h800000;
    localparam int PHASE_ITEMS = 150;
    localparam int SETTLE_CYCLES = 60;

    typedef struct packed {
        logic [rsd_pkg::ROOT_W-1:0] std_dev;
        logic                       window_full;
    } deviation_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [rsd_pkg::SAMPLE_W-1:0] s_sample = '0;
    logic                         s_series_start = 1'b0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [rsd_pkg::ROOT_W-1:0]   m_std_dev;
    logic                         m_window_full;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [rsd_pkg::WL_W-1:0]     cfg_data = '0;

    // Scoreboard model of the window.
    logic [rsd_pkg::SAMPLE_W-1:0] ring_samples [rsd_pkg::MAX_WINDOW];
    logic [rsd_pkg::WL_W-1:0]     window_reg;
    int unsigned                  ring_slot;
    int unsigned                  seen_count;
    longint                       running_total;
    longint unsigned              running_squares;

    deviation_t pending_deviations [$];
    int         error_count = 0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;

    rolling_standard_deviation_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .s_series_start (s_series_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_std_dev      (m_std_dev),
        .m_window_full  (m_window_full),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99, 0) >= stall_pct);
    end

    function automatic void clear_history();
        ring_slot = 0;
        seen_count = 0;
        running_total = 0;
        running_squares = 0;
    endfunction

    function automatic int unsigned effective_window();
        int unsigned p;
        p = window_reg;
        if (p < 1) p = 1;
        if (p > rsd_pkg::MAX_WINDOW) p = rsd_pkg::MAX_WINDOW;
        return p;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = rsd_pkg::ROOT_W; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    function automatic deviation_t predict_deviation(
        logic [rsd_pkg::SAMPLE_W-1:0] sample, logic series_start);
        deviation_t      result;
        int unsigned     p;
        int unsigned     old_slot;
        longint          x;
        longint          old;
        longint unsigned mag;
        longint unsigned num;
        longint unsigned sq;
        longint unsigned variance;
        p = effective_window();
        x = longint'($signed(sample));
        if (series_start) clear_history();
        // Once the window is full the oldest sample drops out before the new one enters.
        if (seen_count >= p) begin
            old_slot = (ring_slot + rsd_pkg::MAX_WINDOW - p) % rsd_pkg::MAX_WINDOW;
            old = longint'($signed(ring_samples[old_slot]));
            running_total -= old;
            running_squares -= longint'(unsigned'(old * old));
        end else begin
            seen_count++;
        end
        ring_samples[ring_slot] = sample;
        ring_slot = (ring_slot + 1) % rsd_pkg::MAX_WINDOW;
        running_total += x;
        running_squares += longint'(unsigned'(x * x));
        result = '0;
        if (seen_count >= p) begin
            mag = (running_total < 0) ? -running_total : running_total;
            num = p * running_squares;
            sq = mag * mag;
            variance = (num > sq) ? (num - sq) / (p * p) : 0;
            result.std_dev = rsd_pkg::ROOT_W'(floor_sqrt(variance));
            result.window_full = 1'b1;
        end
        return result;
    endfunction

    always @(posedge aclk) begin
        deviation_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_deviations.size() == 0) begin
                $error("result word with no expectation: std_dev %0d window_full %0b",
                       m_std_dev, m_window_full);
                error_count++;
            end else begin
                want = pending_deviations.pop_front();
                if (m_std_dev !== want.std_dev) begin
                    $error("std_dev mismatch: expected %0d, actual %0d",
                           want.std_dev, m_std_dev);
                    error_count++;
                end
                if (m_window_full !== want.window_full) begin
                    $error("window_full mismatch: expected %0b, actual %0b",
                           want.window_full, m_window_full);
                    error_count++;
                end
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance with
    // s_valid still high so that back-to-back words need no extra assignment.
    task automatic send_sample(logic [rsd_pkg::SAMPLE_W-1:0] sample, logic series_start);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_sample <= sample;
        s_series_start <= series_start;
        do @(posedge aclk); while (!s_ready);
        pending_deviations.push_back(predict_deviation(sample, series_start));
        @(negedge aclk);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_deviations.size() != 0) @(negedge aclk);
    endtask

    // The block must be idle: every word sent so far has been taken.
    task automatic write_window(logic [rsd_pkg::WL_W-1:0] length);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data <= length;
        do @(posedge aclk); while (!cfg_ready);
        window_reg = length;
        clear_history();
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idle_mode(int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 55; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 55; end
            default: begin send_idle_pct = 16; stall_pct = 16; end
        endcase
    endtask

    function automatic logic [rsd_pkg::SAMPLE_W-1:0] next_sample(
        int kind, logic [rsd_pkg::SAMPLE_W-1:0] base);
        logic [31:0] r;
        r = $urandom;
        case (kind)
            0: return r[rsd_pkg::SAMPLE_W-1:0];
            1: return base + rsd_pkg::SAMPLE_W'($urandom_range(64, 0))
                      - rsd_pkg::SAMPLE_W'(32);
            2: return r[0] ? SAMPLE_MAX : SAMPLE_MIN;
            default: return base;
        endcase
    endfunction

    // Window of 20 from reset, filled with alternating extremes.
    task automatic test_reset_window();
        set_idle_mode(0);
        for (int i = 0; i < 20; i++) send_sample(i[0] ? SAMPLE_MIN : SAMPLE_MAX, i == 0);
    endtask

    // A length of zero acts as one; a window of one always gives zero.
    task automatic test_degenerate_windows();
        write_window(7'd0);
        send_sample(24'd5, 1'b0);
        write_window(7'd1);
        send_sample(SAMPLE_MIN, 1'b0);
    endtask

    // Rewriting the length and raising series_start both restart the window.
    task automatic test_history_clearing();
        write_window(7'd2);
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MIN, 1'b0);
        write_window(7'd2);
        send_sample(24'd0, 1'b0);
        send_sample(24'd100, 1'b0);
        send_sample(24'd5, 1'b1);
    endtask

    task automatic test_random_traffic();
        int              lengths [12] = '{5, 127, 1, 64, 0, 17, 65, 2, -1, 63, 32, -1};
        int unsigned     p;
        int unsigned     span;
        int              kind;
        int              sent;
        logic            start;
        logic [31:0]     r;
        for (int ph = 0; ph < 12; ph++) begin
            write_window((lengths[ph] < 0) ? rsd_pkg::WL_W'($urandom_range(64, 1))
                                           : rsd_pkg::WL_W'(lengths[ph]));
            set_idle_mode(ph % 4);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                p = effective_window();
                // Mostly series long enough to fill and roll the window.
                if ($urandom_range(9, 0) < 8) span = $urandom_range(2 * p + 4, p);
                else span = $urandom_range(p, 1);
                kind = $urandom_range(3, 0);
                r = $urandom;
                for (int i = 0; i < span && sent < PHASE_ITEMS; i++) begin
                    if (i == 0) start = ($urandom_range(9, 0) != 0);
                    else start = ($urandom_range(99, 0) == 0);
                    send_sample(next_sample(kind, r[rsd_pkg::SAMPLE_W-1:0]), start);
                    sent++;
                end
                if ($urandom_range(29, 0) == 0) wait_for_results();
            end
        end
    endtask

    initial begin
        window_reg = rsd_pkg::WL_RESET;
        clear_history();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_window();
        test_degenerate_windows();
        test_history_clearing();
        test_random_traffic();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_deviations.size() != 0) begin
            $error("%0d expected words never arrived", pending_deviations.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
